// ===== rtl/wfps_pkg.sv =====
package wfps_pkg;

    localparam int FRAME_LEN       = 400;
    localparam int BINS_PER_RESULT = 4;
    localparam int GRP_BINS        = (BINS_PER_RESULT > 4) ? 4 :
                                     ((BINS_PER_RESULT < 1) ? 1 : BINS_PER_RESULT);

    function automatic int count_twos(input int n);
        int v;
        int c;
        v = n;
        c = 0;
        while ((v % 2) == 0 && v > 1) begin
            v = v / 2;
            c = c + 1;
        end
        return c;
    endfunction

    localparam int LEVELS     = count_twos(FRAME_LEN);
    localparam int ODD_LEN    = FRAME_LEN >> LEVELS;
    localparam int NUM_LEAVES = 1 << LEVELS;
    localparam int ADDR_W     = $clog2(FRAME_LEN);
    localparam int FILL_W     = $clog2(FRAME_LEN + 1);
    localparam int ODD_W      = (ODD_LEN > 1) ? $clog2(ODD_LEN) : 1;
    localparam int LEAF_W     = (LEVELS > 0) ? LEVELS : 1;
    localparam int NB_MAX     = FRAME_LEN / 2 + 1;
    localparam int SMP_W      = 16;
    localparam int COEF_W     = 17;
    localparam int DATA_W     = 32;
    localparam int PWR_W      = 48;

    localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
    localparam logic [63:0] Q30_ONE      = 64'd1073741824;
    localparam int          TAYLOR_TERMS = 10;

    localparam int TAB_COS  = 0;
    localparam int TAB_SIN  = 1;
    localparam int TAB_HANN = 2;

    typedef logic signed [COEF_W-1:0] coef_tab_t [FRAME_LEN];

    typedef struct packed {
        logic signed [SMP_W-1:0] sample;
        logic                    frame_end;
    } in_word_t;

    typedef struct packed {
        logic [7:0]                 first_bin;
        logic [3:0][PWR_W-1:0]      power;
        logic                       last;
    } grp_t;

    function automatic logic signed [63:0] q30_to_q15(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = v;
        if (t < 0) t = 0;
        if (t > $signed(Q30_ONE)) t = $signed(Q30_ONE);
        return (t + 64'sd16384) >>> 15;
    endfunction

    function automatic coef_tab_t build_tab(input int mode);
        coef_tab_t          tab;
        logic [63:0]        q4, quad, r, th, t2, st, ct;
        logic signed [63:0] s, c, sq, cq, cv, sv;
        for (int i = 0; i < FRAME_LEN; i++) begin
            q4   = 64'(4 * i);
            quad = q4 / FRAME_LEN;
            r    = q4 % FRAME_LEN;
            th   = (HALF_PI_Q30 / FRAME_LEN) * r + ((HALF_PI_Q30 % FRAME_LEN) * r) / FRAME_LEN;
            t2   = (th * th) >> 30;
            st   = th;
            ct   = Q30_ONE;
            s    = $signed(th);
            c    = $signed(Q30_ONE);
            for (int k = 1; k < TAYLOR_TERMS; k++) begin
                st = ((st * t2) >> 30) / 64'((2 * k) * (2 * k + 1));
                ct = ((ct * t2) >> 30) / 64'((2 * k - 1) * (2 * k));
                if ((k % 2) == 1) begin
                    s = s - $signed(st);
                    c = c - $signed(ct);
                end else begin
                    s = s + $signed(st);
                    c = c + $signed(ct);
                end
            end
            sq = q30_to_q15(s);
            cq = q30_to_q15(c);
            case (quad[1:0])
                2'd0: begin cv = cq;  sv = sq;  end
                2'd1: begin cv = -sq; sv = cq;  end
                2'd2: begin cv = -cq; sv = -sq; end
                default: begin cv = sq; sv = -cq; end
            endcase
            if (mode == TAB_COS) begin
                tab[i] = COEF_W'(cv);
            end else if (mode == TAB_SIN) begin
                tab[i] = COEF_W'(sv);
            end else begin
                tab[i] = COEF_W'((64'sd32769 - cv) >>> 1);
            end
        end
        return tab;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -36'sd2147483648) return 32'sh80000000;
        return v[DATA_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] add_mod(input logic [ADDR_W-1:0] a,
                                                  input logic [ADDR_W-1:0] b);
        logic [ADDR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (ADDR_W + 1)'(FRAME_LEN)) s = s - (ADDR_W + 1)'(FRAME_LEN);
        return s[ADDR_W-1:0];
    endfunction

endpackage

// ===== rtl/wfps_coef_rom.sv =====
module wfps_coef_rom (
    input  logic                                aclk,
    input  logic [wfps_pkg::ADDR_W-1:0]         hann_addr,
    input  logic [wfps_pkg::ADDR_W-1:0]         tw_addr,
    output logic signed [wfps_pkg::COEF_W-1:0]  hann_q,
    output logic signed [wfps_pkg::COEF_W-1:0]  cos_q,
    output logic signed [wfps_pkg::COEF_W-1:0]  sin_q
);
    import wfps_pkg::*;

    localparam coef_tab_t COS_TAB  = build_tab(TAB_COS);
    localparam coef_tab_t SIN_TAB  = build_tab(TAB_SIN);
    localparam coef_tab_t HANN_TAB = build_tab(TAB_HANN);

    always_ff @(posedge aclk) begin
        hann_q <= HANN_TAB[hann_addr];
        cos_q  <= COS_TAB[tw_addr];
        sin_q  <= SIN_TAB[tw_addr];
    end

endmodule

// ===== rtl/wfps_engine.sv =====
module wfps_engine (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  wfps_pkg::in_word_t in_word,
    output logic               in_ready,
    input  logic [7:0]         num_bins,
    output logic               grp_valid,
    output wfps_pkg::grp_t     grp,
    input  logic               grp_ready
);
    import wfps_pkg::*;

    typedef enum logic [10:0] {
        ST_LOAD   = 11'b00000000001,
        ST_DFT    = 11'b00000000010,
        ST_DRAIN  = 11'b00000000100,
        ST_BF_RD  = 11'b00000001000,
        ST_BF_MUL = 11'b00000010000,
        ST_BF_ADD = 11'b00000100000,
        ST_BF_WR2 = 11'b00001000000,
        ST_PW_RD  = 11'b00010000000,
        ST_PW_SQ  = 11'b00100000000,
        ST_PW_SUM = 11'b01000000000,
        ST_PUSH   = 11'b10000000000
    } state_t;

    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last;
        logic              zero;
        logic [ADDR_W-1:0] tw;
        logic [ADDR_W-1:0] oaddr;
    } tag_t;

    logic signed [SMP_W-1:0]  frame_mem [FRAME_LEN];
    logic [2*DATA_W-1:0]      work_mem  [FRAME_LEN];

    state_t state_reg, state_next;
    logic [FILL_W-1:0] fill_reg;

    logic [LEAF_W-1:0] leaf_reg;
    logic [ODD_W-1:0]  kk_reg, jj_reg;
    logic [ADDR_W-1:0] kstep_reg, tw_reg, oaddr_reg;
    tag_t              pipe1_reg, pipe2_reg, pipe3_reg, pipe4_reg;

    logic signed [SMP_W-1:0]        frame_q_reg;
    logic signed [SMP_W+COEF_W-1:0] p1_reg;
    logic signed [COEF_W-1:0]       win_reg;
    logic signed [2*COEF_W-1:0]     pr_reg, pi_reg;
    logic signed [DATA_W-1:0]       acc_re_reg, acc_im_reg;

    logic [ADDR_W-1:0] bk_reg, blk_reg, h_reg, tstep_reg, bftw_reg;
    logic signed [DATA_W+18-1:0] prod_rr_reg, prod_ii_reg, prod_ir_reg, prod_ri_reg;
    logic [2*DATA_W-1:0]         e_reg;
    logic signed [DATA_W-1:0]    diff_re_reg, diff_im_reg;

    logic [8:0]             first_reg;
    logic [1:0]             slot_reg;
    logic [3:0][PWR_W-1:0]  slots_reg;
    logic [63:0]            sq_re_reg, sq_im_reg;

    logic [2*DATA_W-1:0] rd_a_q, rd_b_q;

    logic signed [COEF_W-1:0] hann_q, cos_q, sin_q;
    logic [ADDR_W-1:0]        tw_addr;

    logic [LEAF_W-1:0] rev;
    logic [ADDR_W-1:0] fa;
    logic              accept, dft_end, pipe_empty;
    logic [ADDR_W-1:0] e_addr, o_addr, rd_a_addr;
    logic [ADDR_W:0]   blk_sum, two_h;
    logic              blk_end, lvl_end, bf_done;
    logic [8:0]        bin;
    logic [7:0]        nb;
    logic              pw_take, grp_last;

    logic signed [SMP_W-1:0]        fmask;
    logic signed [SMP_W+COEF_W-1:0] win_full;
    logic signed [2*COEF_W-1:0]     rpr, rpi;
    logic signed [DATA_W-1:0]       base_re, base_im, sum_re, sum_im;
    logic signed [17:0]             wr, wi;
    logic signed [DATA_W-1:0]       o_re, o_im, e_re, e_im;
    logic signed [DATA_W+18-1:0]    m_rr, m_ii, m_ir, m_ri, tr, ti;
    logic signed [DATA_W-1:0]       bsum_re, bsum_im;
    logic signed [DATA_W-1:0]       pw_re, pw_im;
    logic [63:0]                    pw_sum;
    logic [PWR_W-1:0]               pw_sat;

    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [2*DATA_W-1:0]  wr_data;

    wfps_coef_rom u_rom (
        .aclk      (aclk),
        .hann_addr (fa),
        .tw_addr   (tw_addr),
        .hann_q    (hann_q),
        .cos_q     (cos_q),
        .sin_q     (sin_q)
    );

    always_comb begin
        rev = '0;
        for (int b = 0; b < LEVELS; b++) rev[b] = leaf_reg[LEVELS-1-b];
        fa = ADDR_W'(rev) + (ADDR_W'(jj_reg) << LEVELS);
    end

    assign in_ready   = (state_reg == ST_LOAD);
    assign accept     = in_valid && in_ready;
    assign dft_end    = (leaf_reg == LEAF_W'(NUM_LEAVES - 1)) &&
                        (kk_reg == ODD_W'(ODD_LEN - 1)) && (jj_reg == ODD_W'(ODD_LEN - 1));
    assign pipe_empty = !(pipe1_reg.valid || pipe2_reg.valid ||
                          pipe3_reg.valid || pipe4_reg.valid);

    assign e_addr  = blk_reg + bk_reg;
    assign o_addr  = e_addr + h_reg;
    assign two_h   = {h_reg, 1'b0};
    assign blk_sum = {1'b0, blk_reg} + two_h;
    assign blk_end = (bk_reg == h_reg - ADDR_W'(1));
    assign lvl_end = blk_end && (blk_sum == (ADDR_W + 1)'(FRAME_LEN));
    assign bf_done = lvl_end && (two_h == (ADDR_W + 1)'(FRAME_LEN));

    always_comb begin
        if (num_bins == 8'd0) begin
            nb = 8'd1;
        end else if (int'(num_bins) > NB_MAX) begin
            nb = 8'(NB_MAX);
        end else begin
            nb = num_bins;
        end
    end

    assign bin       = first_reg + 9'(slot_reg);
    assign pw_take   = (int'(slot_reg) < GRP_BINS) && (bin < {1'b0, nb});
    assign grp_last  = (first_reg + 9'(GRP_BINS)) >= {1'b0, nb};
    assign rd_a_addr = (state_reg == ST_PW_RD) ? ADDR_W'(bin) : e_addr;
    assign tw_addr   = (state_reg == ST_BF_RD) ? bftw_reg : pipe2_reg.tw;

    // direct DFT datapath
    always_comb begin
        fmask    = pipe1_reg.zero ? '0 : frame_q_reg;
        win_full = (p1_reg + (SMP_W + COEF_W)'(16384)) >>> 15;
        rpr      = (pr_reg + (2 * COEF_W)'(16384)) >>> 15;
        rpi      = (pi_reg + (2 * COEF_W)'(16384)) >>> 15;
        base_re  = pipe4_reg.first ? '0 : acc_re_reg;
        base_im  = pipe4_reg.first ? '0 : acc_im_reg;
        sum_re   = sat32(36'(base_re) + 36'(rpr));
        sum_im   = sat32(36'(base_im) - 36'(rpi));
    end

    // butterfly datapath
    always_comb begin
        wr      = 18'(cos_q);
        wi      = -18'(sin_q);
        o_re    = rd_b_q[2*DATA_W-1:DATA_W];
        o_im    = rd_b_q[DATA_W-1:0];
        e_re    = e_reg[2*DATA_W-1:DATA_W];
        e_im    = e_reg[DATA_W-1:0];
        m_rr    = (prod_rr_reg + (DATA_W + 18)'(16384)) >>> 15;
        m_ii    = (prod_ii_reg + (DATA_W + 18)'(16384)) >>> 15;
        m_ir    = (prod_ir_reg + (DATA_W + 18)'(16384)) >>> 15;
        m_ri    = (prod_ri_reg + (DATA_W + 18)'(16384)) >>> 15;
        tr      = m_rr - m_ii;
        ti      = m_ir + m_ri;
        bsum_re = sat32(36'(e_re) + 36'(tr));
        bsum_im = sat32(36'(e_im) + 36'(ti));
    end

    // power datapath
    always_comb begin
        pw_re  = rd_a_q[2*DATA_W-1:DATA_W];
        pw_im  = rd_a_q[DATA_W-1:0];
        pw_sum = sq_re_reg + sq_im_reg;
        pw_sat = (pw_sum > 64'hFFFF_FFFF_FFFF) ? '1 : pw_sum[PWR_W-1:0];
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = pipe4_reg.oaddr;
        wr_data = {sum_re, sum_im};
        if (pipe4_reg.valid && pipe4_reg.last) begin
            wr_en = 1'b1;
        end else if (state_reg == ST_BF_ADD) begin
            wr_en   = 1'b1;
            wr_addr = e_addr;
            wr_data = {bsum_re, bsum_im};
        end else if (state_reg == ST_BF_WR2) begin
            wr_en   = 1'b1;
            wr_addr = o_addr;
            wr_data = {diff_re_reg, diff_im_reg};
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (accept && (in_word.frame_end ||
                               (fill_reg + FILL_W'(1)) == FILL_W'(FRAME_LEN))) begin
                    state_next = ST_DFT;
                end
            end
            ST_DFT: begin
                if (dft_end) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (pipe_empty) state_next = (LEVELS == 0) ? ST_PW_RD : ST_BF_RD;
            end
            ST_BF_RD:  state_next = ST_BF_MUL;
            ST_BF_MUL: state_next = ST_BF_ADD;
            ST_BF_ADD: state_next = ST_BF_WR2;
            ST_BF_WR2: state_next = bf_done ? ST_PW_RD : ST_BF_RD;
            ST_PW_RD: begin
                if (pw_take) begin
                    state_next = ST_PW_SQ;
                end else if (slot_reg == 2'd3) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PW_SQ:  state_next = ST_PW_SUM;
            ST_PW_SUM: state_next = (slot_reg == 2'd3) ? ST_PUSH : ST_PW_RD;
            ST_PUSH: begin
                if (grp_ready) state_next = grp_last ? ST_LOAD : ST_PW_RD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    assign grp_valid     = (state_reg == ST_PUSH);
    assign grp.first_bin = first_reg[7:0];
    assign grp.power     = slots_reg;
    assign grp.last      = grp_last;

    // memories
    always_ff @(posedge aclk) begin
        if (accept) frame_mem[fill_reg[ADDR_W-1:0]] <= in_word.sample;
        frame_q_reg <= frame_mem[fa];
    end

    always_ff @(posedge aclk) begin
        if (wr_en) work_mem[wr_addr] <= wr_data;
        rd_a_q <= work_mem[rd_a_addr];
        rd_b_q <= work_mem[o_addr];
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_LOAD;
            fill_reg        <= '0;
            pipe1_reg.valid <= 1'b0;
            pipe2_reg.valid <= 1'b0;
            pipe3_reg.valid <= 1'b0;
            pipe4_reg.valid <= 1'b0;
        end else begin
            state_reg       <= state_next;
            pipe1_reg.valid <= (state_reg == ST_DFT);
            pipe2_reg.valid <= pipe1_reg.valid;
            pipe3_reg.valid <= pipe2_reg.valid;
            pipe4_reg.valid <= pipe3_reg.valid;
            if (accept) fill_reg <= fill_reg + FILL_W'(1);
            if (state_reg == ST_PUSH && grp_ready && grp_last) fill_reg <= '0;
        end
    end

    // sequencing counters and datapath registers
    always_ff @(posedge aclk) begin
        pipe1_reg.first <= (jj_reg == '0);
        pipe1_reg.last  <= (jj_reg == ODD_W'(ODD_LEN - 1));
        pipe1_reg.zero  <= (FILL_W'(fa) >= fill_reg);
        pipe1_reg.tw    <= tw_reg;
        pipe1_reg.oaddr <= oaddr_reg;
        pipe2_reg.first <= pipe1_reg.first;
        pipe2_reg.last  <= pipe1_reg.last;
        pipe2_reg.zero  <= pipe1_reg.zero;
        pipe2_reg.tw    <= pipe1_reg.tw;
        pipe2_reg.oaddr <= pipe1_reg.oaddr;
        pipe3_reg.first <= pipe2_reg.first;
        pipe3_reg.last  <= pipe2_reg.last;
        pipe3_reg.zero  <= pipe2_reg.zero;
        pipe3_reg.tw    <= pipe2_reg.tw;
        pipe3_reg.oaddr <= pipe2_reg.oaddr;
        pipe4_reg.first <= pipe3_reg.first;
        pipe4_reg.last  <= pipe3_reg.last;
        pipe4_reg.zero  <= pipe3_reg.zero;
        pipe4_reg.tw    <= pipe3_reg.tw;
        pipe4_reg.oaddr <= pipe3_reg.oaddr;

        p1_reg  <= fmask * hann_q;
        win_reg <= win_full[COEF_W-1:0];
        pr_reg  <= win_reg * cos_q;
        pi_reg  <= win_reg * sin_q;
        if (pipe4_reg.valid) begin
            acc_re_reg <= sum_re;
            acc_im_reg <= sum_im;
        end

        case (state_reg)
            ST_LOAD: begin
                leaf_reg  <= '0;
                kk_reg    <= '0;
                jj_reg    <= '0;
                kstep_reg <= '0;
                tw_reg    <= '0;
                oaddr_reg <= '0;
            end
            ST_DFT: begin
                if (jj_reg == ODD_W'(ODD_LEN - 1)) begin
                    jj_reg    <= '0;
                    tw_reg    <= '0;
                    oaddr_reg <= oaddr_reg + ADDR_W'(1);
                    if (kk_reg == ODD_W'(ODD_LEN - 1)) begin
                        kk_reg    <= '0;
                        kstep_reg <= '0;
                        leaf_reg  <= leaf_reg + LEAF_W'(1);
                    end else begin
                        kk_reg    <= kk_reg + ODD_W'(1);
                        kstep_reg <= add_mod(kstep_reg, ADDR_W'(NUM_LEAVES));
                    end
                end else begin
                    jj_reg <= jj_reg + ODD_W'(1);
                    tw_reg <= add_mod(tw_reg, kstep_reg);
                end
            end
            ST_DRAIN: begin
                h_reg     <= ADDR_W'(ODD_LEN);
                tstep_reg <= ADDR_W'(NUM_LEAVES >> 1);
                blk_reg   <= '0;
                bk_reg    <= '0;
                bftw_reg  <= '0;
                first_reg <= '0;
                slot_reg  <= '0;
            end
            ST_BF_MUL: begin
                e_reg       <= rd_a_q;
                prod_rr_reg <= o_re * wr;
                prod_ii_reg <= o_im * wi;
                prod_ir_reg <= o_im * wr;
                prod_ri_reg <= o_re * wi;
            end
            ST_BF_ADD: begin
                diff_re_reg <= sat32(36'(e_re) - 36'(tr));
                diff_im_reg <= sat32(36'(e_im) - 36'(ti));
            end
            ST_BF_WR2: begin
                if (blk_end) begin
                    bk_reg   <= '0;
                    bftw_reg <= '0;
                    if (lvl_end) begin
                        blk_reg   <= '0;
                        h_reg     <= h_reg << 1;
                        tstep_reg <= tstep_reg >> 1;
                    end else begin
                        blk_reg <= blk_sum[ADDR_W-1:0];
                    end
                end else begin
                    bk_reg   <= bk_reg + ADDR_W'(1);
                    bftw_reg <= bftw_reg + tstep_reg;
                end
                first_reg <= '0;
                slot_reg  <= '0;
            end
            ST_PW_RD: begin
                if (!pw_take) begin
                    slots_reg[slot_reg] <= '0;
                    if (slot_reg != 2'd3) slot_reg <= slot_reg + 2'd1;
                end
            end
            ST_PW_SQ: begin
                sq_re_reg <= 64'(pw_re) * 64'(pw_re);
                sq_im_reg <= 64'(pw_im) * 64'(pw_im);
            end
            ST_PW_SUM: begin
                slots_reg[slot_reg] <= pw_sat;
                if (slot_reg != 2'd3) slot_reg <= slot_reg + 2'd1;
            end
            ST_PUSH: begin
                if (grp_ready) begin
                    first_reg <= first_reg + 9'(GRP_BINS);
                    slot_reg  <= '0;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/windowed_fft_power_spectrum.sv =====
// Input: one sample word per cycle while s_tready is high; s_tready drops for the whole
// transform: direct 25-point DFTs on one MAC pipeline, then 800 butterflies (read,
// multiply, add, write states each), then the power of each bin (read, square, sum).
// Reset (synchronous, aresetn low): control and fill count cleared, num_bins = 201;
// sample and work stores are not cleared, unfilled samples read as zero via the fill count.
module windowed_fft_power_spectrum (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // [15:0] sample
    input  logic         s_tlast,   // frame_end
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [199:0] m_tdata,   // first_bin, power_a, power_b, power_c, power_d
    output logic         m_tlast,   // last_group
    input  logic         cfg_wr_en,
    input  logic [7:0]   cfg_wr_data
);
    import wfps_pkg::*;

    logic       num_bins_reg;
    logic [7:0] nbins_reg;
    in_word_t   in_word;
    logic       grp_valid, grp_ready;
    grp_t       grp;
    logic       m_valid_reg;
    logic [199:0] m_data_reg;
    logic       m_last_reg;

    assign in_word.sample    = s_tdata;
    assign in_word.frame_end = s_tlast;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nbins_reg    <= 8'd201;
            num_bins_reg <= 1'b0;
        end else begin
            num_bins_reg <= cfg_wr_en;
            if (cfg_wr_en) nbins_reg <= cfg_wr_data;
        end
    end

    wfps_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_word   (in_word),
        .in_ready  (s_tready),
        .num_bins  (nbins_reg),
        .grp_valid (grp_valid),
        .grp       (grp),
        .grp_ready (grp_ready)
    );

    assign grp_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (grp_valid && grp_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (grp_valid && grp_ready) begin
            m_data_reg <= {grp.power[3], grp.power[2], grp.power[1], grp.power[0],
                           grp.first_bin};
            m_last_reg <= grp.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    a_grp_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (grp_valid && grp_ready) |=> (m_tvalid && m_tdata[7:0] == $past(grp.first_bin)))
        else $error("result word not loaded");

    a_frame_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input taken after frame end");

    a_cfg_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        num_bins_reg |-> nbins_reg == $past(cfg_wr_data))
        else $error("bin count write lost");

endmodule
